/* rtl/delta_rle_frame_decoder_top_defines.svh */
// Assertion macros shared by the delta RLE frame decoder RTL.
`ifndef DELTA_RLE_FRAME_DECODER_TOP_DEFINES_SVH
`define DELTA_RLE_FRAME_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define DRLE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("drle check failed");
// Same-cycle implication.
`define DRLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drle check failed");
`else
`define DRLE_ASSERT(lbl, cond)
`define DRLE_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

/* rtl/drle_pkg.sv */
// Shared constants and types for the delta RLE frame decoder.
package drle_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 512;
  // Position runs 0..FRAME_BYTES (one past the last byte after a final write)
  localparam int POS_W = $clog2(FRAME_BYTES + 1);
  // Two-byte skip count and position + count sum
  localparam int CNT_W = 15;
  localparam int SUM_W = 16;

  // Word field widths
  localparam int CODE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 9;
  localparam int VALUE_W = 8;

  // Blank-frame marker at frame start
  localparam logic [CODE_W-1:0] BLANK_CODE = 8'hFF;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BLANK = 2'd2;

  // Result queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_slot_t;

endpackage

/* rtl/drle_stream_if.sv */
// Valid/ready channel interfaces for coded input and decoded result words.
interface drle_in_if;
  logic                       valid;
  logic                       ready;
  logic [drle_pkg::CODE_W-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface drle_out_if;
  logic                         valid;
  logic                         ready;
  logic [drle_pkg::KIND_W-1:0]  result_kind;
  logic [drle_pkg::INDEX_W-1:0] write_index;
  logic [drle_pkg::VALUE_W-1:0] write_value;

  modport source (output valid, output result_kind, output write_index,
                  output write_value, input ready);
  modport sink   (input valid, input result_kind, input write_index,
                  input write_value, output ready);
endinterface

/* rtl/drle_front.sv */
// Parser: accepts coded bytes, tracks frame position and classifies each word.
module drle_front (
  input  logic                clk,
  input  logic                rst_n,
  drle_in_if.sink             in_ch,
  input  logic                q_full,
  output drle_pkg::res_slot_t push
);

  // Parser phase codes; the unused code behaves as PH_COUNT
  localparam logic [1:0] PH_COUNT     = 2'd0;
  localparam logic [1:0] PH_COUNT_LOW = 2'd1;
  localparam logic [1:0] PH_DATA      = 2'd2;

  logic [1:0]                   phase_r, phase_nxt;
  logic [drle_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [6:0]                   cnt_hi_r, cnt_hi_nxt;
  logic                         at_start_r, at_start_nxt;

  logic                         accept;
  logic [drle_pkg::CODE_W-1:0]  b;
  logic [drle_pkg::SUM_W-1:0]   pos_ext;
  logic [drle_pkg::CNT_W-1:0]   cnt;
  logic [drle_pkg::SUM_W-1:0]   target;
  logic                         ends;

  // Space in the queue is all the parser needs to take a word
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.code_byte;

  // Skip count: one byte, or high bits held from the first byte
  assign pos_ext = drle_pkg::SUM_W'(pos_r);
  assign cnt     = (phase_r == PH_COUNT_LOW) ? {cnt_hi_r, b}
                                             : drle_pkg::CNT_W'(b);
  assign target  = pos_ext + drle_pkg::SUM_W'(cnt);
  assign ends    = (target >= drle_pkg::SUM_W'(drle_pkg::FRAME_BYTES));

  // Next state and result word
  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    cnt_hi_nxt     = cnt_hi_r;
    at_start_nxt   = at_start_r;
    push.valid     = 1'b0;
    push.res.kind  = drle_pkg::KIND_WRITE;
    push.res.index = '0;
    push.res.value = '0;
    if (accept) begin
      case (phase_r)
        PH_DATA: begin
          push.valid     = 1'b1;
          push.res.index = pos_ext[drle_pkg::INDEX_W-1:0];
          push.res.value = b;
          pos_nxt        = pos_r + drle_pkg::POS_W'(1);
          phase_nxt      = PH_COUNT;
        end
        PH_COUNT_LOW: begin
          cnt_hi_nxt = '0;
          if (ends) begin
            push.valid    = 1'b1;
            push.res.kind = drle_pkg::KIND_END;
            phase_nxt     = PH_COUNT;
            pos_nxt       = '0;
            at_start_nxt  = 1'b1;
          end else begin
            pos_nxt      = target[drle_pkg::POS_W-1:0];
            phase_nxt    = PH_DATA;
            at_start_nxt = 1'b0;
          end
        end
        default: begin
          if (at_start_r && (b == drle_pkg::BLANK_CODE)) begin
            // blank frame: stay at frame start
            push.valid    = 1'b1;
            push.res.kind = drle_pkg::KIND_BLANK;
            phase_nxt     = PH_COUNT;
            pos_nxt       = '0;
            cnt_hi_nxt    = '0;
            at_start_nxt  = 1'b1;
          end else if (b[7]) begin
            // first byte of a two-byte count
            cnt_hi_nxt   = b[6:0];
            phase_nxt    = PH_COUNT_LOW;
            at_start_nxt = 1'b0;
          end else if (ends) begin
            push.valid    = 1'b1;
            push.res.kind = drle_pkg::KIND_END;
            phase_nxt     = PH_COUNT;
            pos_nxt       = '0;
            cnt_hi_nxt    = '0;
            at_start_nxt  = 1'b1;
          end else begin
            pos_nxt      = target[drle_pkg::POS_W-1:0];
            phase_nxt    = PH_DATA;
            at_start_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_COUNT;
      pos_r      <= '0;
      cnt_hi_r   <= '0;
      at_start_r <= 1'b1;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      cnt_hi_r   <= cnt_hi_nxt;
      at_start_r <= at_start_nxt;
    end
  end

endmodule

/* rtl/drle_queue.sv */
// Short result queue between the parser and the output stage.
module drle_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  drle_pkg::res_slot_t push,
  input  logic                pop,
  output logic                full,
  output drle_pkg::res_slot_t head
);

  drle_pkg::res_t                 mem_r [drle_pkg::QUEUE_DEPTH];
  logic [drle_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [drle_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [drle_pkg::QCNT_W-1:0]    count_r, count_nxt;

  assign full       = (count_r == drle_pkg::QCNT_W'(drle_pkg::QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.res   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + drle_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + drle_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + drle_pkg::QCNT_W'(1);
    end else if (pop && !push.valid) begin
      count_nxt = count_r - drle_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.res;
    end
  end

endmodule

/* rtl/drle_back.sv */
// Output stage: drains the result queue into the registered result channel.
module drle_back (
  input  logic                clk,
  input  logic                rst_n,
  input  drle_pkg::res_slot_t head,
  output logic                pop,
  drle_out_if.source          out_ch
);

  logic           out_valid_r, out_valid_nxt;
  drle_pkg::res_t out_res_r;

  // Load when the register is empty or its word leaves this cycle
  assign pop = head.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= head.res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_res_r.kind;
  assign out_ch.write_index = out_res_r.index;
  assign out_ch.write_value = out_res_r.value;

endmodule

/* rtl/delta_rle_frame_decoder_top.sv */
// Delta RLE frame decoder: coded bytes in, byte writes and frame markers out.
// Throughput: one coded byte per cycle while the queue has room; the parser state
// updates in one add and compare. Result words pass the queue, then the output register.
// A four-word queue lets input continue while the output is stalled.
// Reset (synchronous, rst_n low): parser at frame start, position 0, queue and output empty.
`include "delta_rle_frame_decoder_top_defines.svh"
module delta_rle_frame_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  drle_in_if.sink    in_ch,
  drle_out_if.source out_ch
);

  drle_pkg::res_slot_t q_push;
  drle_pkg::res_slot_t q_head;
  logic                q_full;
  logic                q_pop;
  logic                out_is_write;
  logic                out_is_marker;
  logic                out_in_frame;
  logic                out_fields_zero;

  // Byte parser
  drle_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (q_push)
  );

  // Result queue
  drle_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .full  (q_full),
    .head  (q_head)
  );

  // Output register
  drle_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  // Output word classification for the checks
  assign out_is_write    = out_ch.valid && (out_ch.result_kind == drle_pkg::KIND_WRITE);
  assign out_is_marker   = out_ch.valid && (out_ch.result_kind != drle_pkg::KIND_WRITE);
  assign out_in_frame    = (32'(out_ch.write_index) < drle_pkg::FRAME_BYTES);
  assign out_fields_zero = (out_ch.write_index == '0) && (out_ch.write_value == '0);

  // Checks
  `DRLE_ASSERT_IMP(a_no_push_when_full, q_push.valid, !q_full)
  `DRLE_ASSERT_IMP(a_pop_needs_entry, q_pop, q_head.valid)
  `DRLE_ASSERT_IMP(a_write_in_frame, out_is_write, out_in_frame)
  `DRLE_ASSERT_IMP(a_marker_fields_zero, out_is_marker, out_fields_zero)

endmodule

/* verif/drle_result_check.sv */
// Channel monitor for the delta RLE frame decoder: predicts result words and compares them.
`timescale 1ns / 100ps
module drle_result_check (
  input  logic clk,
  input  logic rst_n,
  drle_in_if   in_mon,
  drle_out_if  out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   codes_seen,
  output int   writes_seen,
  output int   ends_seen,
  output int   blanks_seen
);
  import drle_pkg::*;

  localparam int PRINT_CAP = 50;
  localparam int HIGH_W    = CNT_W - CODE_W;

  typedef enum logic [1:0] {
    EXPECT_COUNT     = 2'd0,
    EXPECT_COUNT_LOW = 2'd1,
    EXPECT_DATA      = 2'd2
  } parse_phase_t;

  // Shadow parser state
  parse_phase_t      phase_q;
  logic [POS_W-1:0]  pos_q;
  logic [HIGH_W-1:0] count_hi_q;
  logic              at_start_q;

  // Words predicted but not yet seen on the output
  res_t pending_words[$];

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic void restart_frame();
    phase_q    = EXPECT_COUNT;
    pos_q      = '0;
    count_hi_q = '0;
    at_start_q = 1'b1;
  endfunction

  // Advance the shadow parser by one coded byte; returns 1 when a word is due.
  function automatic bit decode_code_byte(input logic [CODE_W-1:0] b, output res_t word);
    logic [CNT_W-1:0] skip;
    logic [SUM_W-1:0] target;
    word = '0;
    skip = '0;
    case (phase_q)
      EXPECT_DATA: begin
        word.kind  = KIND_WRITE;
        word.index = pos_q[INDEX_W-1:0];
        word.value = b;
        pos_q      = pos_q + 1'b1;
        phase_q    = EXPECT_COUNT;
        return 1'b1;
      end
      EXPECT_COUNT_LOW: begin
        skip       = {count_hi_q, b};
        count_hi_q = '0;
      end
      default: begin
        // 0xFF only marks a blank frame as the first byte of a frame
        if (at_start_q && b == BLANK_CODE) begin
          restart_frame();
          word.kind = KIND_BLANK;
          return 1'b1;
        end
        // top bit set: high half of a two-byte count
        if (b[CODE_W-1]) begin
          count_hi_q = b[HIGH_W-1:0];
          phase_q    = EXPECT_COUNT_LOW;
          at_start_q = 1'b0;
          return 1'b0;
        end
        skip = CNT_W'(b);
      end
    endcase
    // complete count: either ends the frame or sets up the data byte
    target = SUM_W'(pos_q) + SUM_W'(skip);
    if (target >= SUM_W'(FRAME_BYTES)) begin
      restart_frame();
      word.kind = KIND_END;
      return 1'b1;
    end
    pos_q      = POS_W'(target);
    phase_q    = EXPECT_DATA;
    at_start_q = 1'b0;
    return 1'b0;
  endfunction

  // Compare output words first, then fold in the byte accepted at this edge
  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (!rst_n) begin
      restart_frame();
      pending_words.delete();
      outstanding <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.result_kind, out_mon.write_index, out_mon.write_value};
        if (got.kind == KIND_WRITE) writes_seen++;
        else if (got.kind == KIND_END) ends_seen++;
        else if (got.kind == KIND_BLANK) blanks_seen++;
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind=%0d index=%0d value=%02h",
                                    got.kind, got.index, got.value));
        end else begin
          want = pending_words.pop_front();
          if (got.kind != want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
          if (got.index != want.index)
            report_mismatch($sformatf("index %0d, expected %0d", got.index, want.index));
          if (got.value != want.value)
            report_mismatch($sformatf("value %02h, expected %02h", got.value, want.value));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        codes_seen++;
        if (decode_code_byte(in_mon.code_byte, want)) pending_words.push_back(want);
      end
      outstanding <= pending_words.size();
    end
  end

endmodule

/* verif/delta_rle_frame_decoder_top_tb.sv */
// Testbench top for the delta RLE frame decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module delta_rle_frame_decoder_top_tb;
  import drle_pkg::*;

  localparam int RANDOM_CODES = 900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 8;
  localparam int MAX_SKIP     = 32767;

  // Directed opener: blank, writes at both ends, one- and two-byte counts,
  // exact-end counts, 0xFF as a two-byte count inside a frame
  localparam logic [CODE_W-1:0] OPENER [23] = '{
    8'hFF,                  // blank frame
    8'h00, 8'h00,           // write position 0
    8'h7F, 8'hFF,           // largest one-byte count, value 0xFF
    8'h80, 8'h00, 8'hA5,    // two-byte count of zero
    8'h81, 8'h6D, 8'h5A,    // two-byte count to position 495
    8'h0F, 8'hC3,           // write the last byte
    8'h00,                  // any count after the last byte ends the frame
    8'hFF, 8'hFF,           // two blank frames in a row
    8'h05, 8'h11,
    8'hFF, 8'hFF,           // 0xFF mid-frame: largest two-byte count
    8'h82, 8'h00,           // count of exactly one frame
    8'h7F
  };

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  int mismatches;
  int outstanding;
  int codes_seen;
  int writes_seen;
  int ends_seen;
  int blanks_seen;

  int cycle_count;
  int burst_left;
  int codes_sent;
  int drain_wait;
  bit held_midway;

  rx_mode_t rx_mode;
  int       rx_window;
  int       rx_stall;

  drle_in_if  in_ch ();
  drle_out_if out_ch ();

  delta_rle_frame_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  drle_result_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .codes_seen  (codes_seen),
    .writes_seen (writes_seen),
    .ends_seen   (ends_seen),
    .blanks_seen (blanks_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d words still expected", cycle_count, outstanding);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result receiver: switches between stall patterns in random windows
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode      <= RX_OPEN;
      rx_window    <= 0;
      rx_stall     <= 0;
    end else begin
      if (rx_window == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        rx_window <= $urandom_range(32, 200);
      end else begin
        rx_window <= rx_window - 1;
      end
      case (rx_mode)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_ch.ready <= (cycle_count % 4 == 0);
        default: begin
          if (rx_stall > 0) begin
            out_ch.ready <= 1'b0;
            rx_stall     <= rx_stall - 1;
          end else begin
            out_ch.ready <= 1'b1;
            rx_stall     <= ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 0;
          end
        end
      endcase
    end
  end

  // One coded byte; opens a new burst after a random gap when the last one is used up
  task automatic send_code(input logic [CODE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.code_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    codes_sent++;
  endtask

  // Stop sending until every predicted word has come out or DRAIN_LIMIT runs out
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    drain_wait = 0;
    do begin
      @(posedge clk);
      drain_wait++;
    end while (outstanding != 0 && drain_wait < DRAIN_LIMIT);
    burst_left = 0;
  endtask

  // Skip count, one byte where it fits (sometimes two bytes anyway)
  task automatic send_skip(input int skip);
    logic [CNT_W-1:0] cnt;
    cnt = CNT_W'(skip);
    if (skip < 128 && $urandom_range(0, 4) != 0) begin
      send_code(cnt[CODE_W-1:0]);
    end else begin
      send_code({1'b1, cnt[CNT_W-1:CODE_W]});
      send_code(cnt[CODE_W-1:0]);
    end
  endtask

  // A well-formed coded frame with random gaps and data
  task automatic send_frame();
    int  pos;
    int  skip;
    bit  done;
    if ($urandom_range(0, 6) == 0) begin
      send_code(BLANK_CODE);
      return;
    end
    pos  = 0;
    done = 1'b0;
    while (!done) begin
      case ($urandom_range(0, 19))
        0:       skip = FRAME_BYTES - 1 - pos;      // land on the last byte
        1:       skip = FRAME_BYTES - pos;          // end exactly at the frame end
        2:       skip = $urandom_range(0, MAX_SKIP);
        3, 4:    skip = $urandom_range(128, 1023);
        5, 6:    skip = $urandom_range(0, 127);
        default: skip = $urandom_range(0, 24);
      endcase
      send_skip(skip);
      if (pos + skip >= FRAME_BYTES) begin
        done = 1'b1;
      end else begin
        send_code(CODE_W'($urandom_range(0, 255)));
        pos += skip + 1;
      end
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.code_byte = '0;
    rst_n           = 1'b0;
    burst_left      = 0;
    codes_sent      = 0;
    held_midway     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENER[i]) send_code(OPENER[i]);
    hold_until_drained();

    // Mostly clean frames, with occasional bursts of noise that knock the parser off
    while (codes_sent < $size(OPENER) + RANDOM_CODES) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) send_code(CODE_W'($urandom_range(0, 255)));
      end else begin
        send_frame();
      end
      if (!held_midway && codes_sent > $size(OPENER) + RANDOM_CODES / 2) begin
        held_midway = 1'b1;
        hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d coded bytes in %0d cycles", codes_seen, cycle_count);
    $display("Words checked: %0d byte writes, %0d frame ends, %0d blank frames",
             writes_seen, ends_seen, blanks_seen);
    if (outstanding != 0)
      $display("ERROR: %0d expected words never came out", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
